### rtl/als_pkg.sv
// Shared types and constants for the aging lottery selector.
// Holds the request/response payloads, the entry layout and the memory port bundle.
// Depends on nothing.
package als_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TICKET_BITS = 16;
    localparam int WIN_BITS    = 16;
    localparam int TOTAL_W     = 22;

    localparam logic [CNT_W-1:0]       CLEAR_INDEX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0]       ENTRY_LIMIT = CNT_W'(MAX_ENTRIES);
    localparam logic [TICKET_BITS-1:0] TICKET_MAX  = '1;
    localparam logic [WIN_BITS-1:0]    WIN_MAX     = '1;
    localparam logic [TICKET_BITS-1:0] TICKET_ONE  = TICKET_BITS'(1);

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_PICK     = 2'd1,
        MODE_SET_LAST = 2'd2,
        MODE_READ     = 2'd3
    } mode_t;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  entry_index;
        logic [15:0] initial_tickets;
        logic [15:0] initial_wins;
        logic [5:0]  random_start;
        logic [21:0] random_draw;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  chosen_index;
        logic [15:0] entry_tickets;
        logic [15:0] entry_wins;
        logic [21:0] eligible_total;
        logic        is_last_winner;
    } rsp_t;

    typedef struct packed {
        logic [WIN_BITS-1:0]    wins;
        logic [TICKET_BITS-1:0] tickets;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

### rtl/als_ram.sv
// Entry memory of the aging lottery selector: one write port, one read port.
// Read data is registered. Depends on als_pkg.
module als_ram (
    input  logic             clk,
    input  als_pkg::mem_req_t mreq,
    output als_pkg::entry_t   rd_data
);
    import als_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        rd_data_reg <= mem[mreq.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/als_ctrl.sv
// Sequencer of the aging lottery selector: decodes a request, walks the entry
// memory for a pick, then sweeps it to age the tickets. Depends on als_pkg.
module als_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  als_pkg::req_t     req,
    input  logic              res_take,
    output logic              busy,
    output logic              res_valid,
    output als_pkg::rsp_t     res,
    output als_pkg::mem_req_t mreq,
    input  als_pkg::entry_t   rd_data
);
    import als_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_WALK,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t                 state_reg,   state_next;
    req_t                   req_reg,     req_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [TOTAL_W-1:0]     total_reg,   total_next;
    logic [IDX_W-1:0]       last_reg,    last_next;
    logic                   has_last_reg, has_last_next;
    logic [TICKET_BITS-1:0] last_tix_reg, last_tix_next;
    logic [IDX_W-1:0]       rd_idx_reg,  rd_idx_next;
    logic                   skip_reg,    skip_next;
    logic [TOTAL_W-1:0]     elig_reg,    elig_next;
    logic [TOTAL_W-1:0]     draw_reg,    draw_next;
    logic [TOTAL_W-1:0]     acc_reg,     acc_next;
    logic [IDX_W-1:0]       winner_reg,  winner_next;
    logic [TICKET_BITS-1:0] win_tix_reg, win_tix_next;
    logic [WIN_BITS-1:0]    win_wins_reg, win_wins_next;
    rsp_t                   res_reg,     res_next;

    logic [CNT_W-1:0]       count_m1;
    logic [TOTAL_W-1:0]     last_sub;
    logic [TOTAL_W-1:0]     elig_now;
    logic [TOTAL_W-1:0]     tix_ext;
    logic [TOTAL_W-1:0]     pick_elig;
    logic [TOTAL_W-1:0]     add_total;
    logic [CNT_W-1:0]       start_ext;
    logic [IDX_W-1:0]       start_c;
    logic [IDX_W-1:0]       idx_req;
    logic                   idx_ok;
    logic                   walk_take;
    logic [TOTAL_W:0]       walk_sum;
    logic                   walk_hit;
    logic [IDX_W-1:0]       walk_wrap;
    logic                   upd_win;
    logic [TICKET_BITS-1:0] new_tix;
    logic [WIN_BITS-1:0]    new_wins;
    logic [TOTAL_W-1:0]     upd_sum;
    logic [TICKET_BITS-1:0] fin_tix;
    logic [WIN_BITS-1:0]    fin_wins;

    always_comb
    begin
        count_m1  = count_reg - CNT_W'(1);
        last_sub  = has_last_reg ? TOTAL_W'(last_tix_reg) : '0;
        elig_now  = total_reg - last_sub;
        tix_ext   = TOTAL_W'(rd_data.tickets);
        add_total = total_reg + TOTAL_W'(req_reg.initial_tickets);
        pick_elig = (has_last_reg && (count_reg > CNT_W'(1))) ?
                    (total_reg - TOTAL_W'(last_tix_reg)) : total_reg;
        start_ext = CNT_W'(req_reg.random_start);
        start_c   = (start_ext >= count_reg) ? count_m1[IDX_W-1:0] : start_ext[IDX_W-1:0];
        idx_req   = req_reg.entry_index[IDX_W-1:0];
        idx_ok    = req_reg.entry_index < count_reg;

        // walk: data of rd_idx_reg arrives this cycle
        walk_take = !(skip_reg && (rd_idx_reg == last_reg));
        walk_sum  = {1'b0, acc_reg} + {1'b0, tix_ext};
        walk_hit  = walk_take && ((elig_reg == '0) || (walk_sum > {1'b0, draw_reg}));
        walk_wrap = ({1'b0, rd_idx_reg} == count_m1) ? '0 : rd_idx_reg + IDX_W'(1);

        // aging sweep
        upd_win = rd_idx_reg == winner_reg;
        if (upd_win)
        begin
            new_tix  = (rd_data.tickets > TICKET_ONE) ?
                       rd_data.tickets - TICKET_ONE : rd_data.tickets;
            new_wins = (rd_data.wins != WIN_MAX) ?
                       rd_data.wins + WIN_BITS'(1) : rd_data.wins;
        end
        else
        begin
            new_tix  = (rd_data.tickets != TICKET_MAX) ?
                       rd_data.tickets + TICKET_ONE : rd_data.tickets;
            new_wins = rd_data.wins;
        end
        upd_sum  = acc_reg + TOTAL_W'(new_tix);
        fin_tix  = upd_win ? new_tix  : win_tix_reg;
        fin_wins = upd_win ? new_wins : win_wins_reg;

        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        last_next     = last_reg;
        has_last_next = has_last_reg;
        last_tix_next = last_tix_reg;
        rd_idx_next   = rd_idx_reg;
        skip_next     = skip_reg;
        elig_next     = elig_reg;
        draw_next     = draw_reg;
        acc_next      = acc_reg;
        winner_next   = winner_reg;
        win_tix_next  = win_tix_reg;
        win_wins_next = win_wins_reg;
        res_next      = res_reg;

        mreq.wr_en   = 1'b0;
        mreq.wr_addr = rd_idx_reg;
        mreq.wr_data = '{wins: new_wins, tickets: new_tix};
        mreq.rd_addr = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_next                = '0;
                res_next.eligible_total = elig_now;
                state_next              = ST_DONE;
                unique case (req_reg.mode)
                    MODE_ADD:
                    begin
                        if (count_reg >= ENTRY_LIMIT)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = count_reg[IDX_W-1:0];
                            mreq.wr_data = '{wins: req_reg.initial_wins,
                                             tickets: req_reg.initial_tickets};
                            count_next   = count_reg + CNT_W'(1);
                            total_next   = add_total;
                            res_next.status         = STATUS_OK;
                            res_next.chosen_index   = count_reg[IDX_W-1:0];
                            res_next.entry_tickets  = req_reg.initial_tickets;
                            res_next.entry_wins     = req_reg.initial_wins;
                            res_next.eligible_total = add_total - last_sub;
                        end
                    end
                    MODE_PICK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = STATUS_INVALID;
                        end
                        else
                        begin
                            // clamp the draw; a draw at or above the total wraps to zero
                            skip_next    = has_last_reg && (count_reg > CNT_W'(1));
                            elig_next    = pick_elig;
                            draw_next    = (req_reg.random_draw >= pick_elig) ?
                                           '0 : req_reg.random_draw;
                            acc_next     = '0;
                            mreq.rd_addr = start_c;
                            rd_idx_next  = start_c;
                            state_next   = ST_WALK;
                        end
                    end
                    MODE_SET_LAST:
                    begin
                        if (idx_ok)
                        begin
                            mreq.rd_addr = idx_req;
                            rd_idx_next  = idx_req;
                            state_next   = ST_RDWAIT;
                        end
                        else
                        begin
                            has_last_next           = 1'b0;
                            last_next               = '0;
                            res_next.eligible_total = total_reg;
                            res_next.status = (req_reg.entry_index >= CLEAR_INDEX) ?
                                              STATUS_OK : STATUS_INVALID;
                        end
                    end
                    MODE_READ:
                    begin
                        if (idx_ok)
                        begin
                            mreq.rd_addr = idx_req;
                            rd_idx_next  = idx_req;
                            state_next   = ST_RDWAIT;
                        end
                        else
                        begin
                            res_next.status = STATUS_INVALID;
                        end
                    end
                endcase
            end

            ST_RDWAIT:
            begin
                res_next.status        = STATUS_OK;
                res_next.chosen_index  = rd_idx_reg;
                res_next.entry_tickets = rd_data.tickets;
                res_next.entry_wins    = rd_data.wins;
                if (req_reg.mode == MODE_SET_LAST)
                begin
                    last_next                = rd_idx_reg;
                    has_last_next            = 1'b1;
                    last_tix_next            = rd_data.tickets;
                    res_next.eligible_total  = total_reg - tix_ext;
                    res_next.is_last_winner  = 1'b1;
                end
                else
                begin
                    res_next.eligible_total  = elig_now;
                    res_next.is_last_winner  = has_last_reg && (last_reg == rd_idx_reg);
                end
                state_next = ST_DONE;
            end

            ST_WALK:
            begin
                if (walk_hit)
                begin
                    // start the aging sweep at entry zero
                    winner_next  = rd_idx_reg;
                    acc_next     = '0;
                    mreq.rd_addr = '0;
                    rd_idx_next  = '0;
                    state_next   = ST_UPD;
                end
                else
                begin
                    if (walk_take)
                    begin
                        acc_next = walk_sum[TOTAL_W-1:0];
                    end
                    mreq.rd_addr = walk_wrap;
                    rd_idx_next  = walk_wrap;
                end
            end

            ST_UPD:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = rd_idx_reg;
                acc_next     = upd_sum;
                if (upd_win)
                begin
                    win_tix_next  = new_tix;
                    win_wins_next = new_wins;
                end
                if ({1'b0, rd_idx_reg} == count_m1)
                begin
                    total_next              = upd_sum;
                    last_next               = winner_reg;
                    has_last_next           = 1'b1;
                    last_tix_next           = fin_tix;
                    res_next.status         = STATUS_OK;
                    res_next.chosen_index   = winner_reg;
                    res_next.entry_tickets  = fin_tix;
                    res_next.entry_wins     = fin_wins;
                    res_next.eligible_total = upd_sum - TOTAL_W'(fin_tix);
                    res_next.is_last_winner = 1'b1;
                    state_next              = ST_DONE;
                end
                else
                begin
                    mreq.rd_addr = rd_idx_reg + IDX_W'(1);
                    rd_idx_next  = rd_idx_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            req_reg      <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            last_reg     <= '0;
            has_last_reg <= 1'b0;
            last_tix_reg <= '0;
            rd_idx_reg   <= '0;
            skip_reg     <= 1'b0;
            elig_reg     <= '0;
            draw_reg     <= '0;
            acc_reg      <= '0;
            winner_reg   <= '0;
            win_tix_reg  <= '0;
            win_wins_reg <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            last_reg     <= last_next;
            has_last_reg <= has_last_next;
            last_tix_reg <= last_tix_next;
            rd_idx_reg   <= rd_idx_next;
            skip_reg     <= skip_next;
            elig_reg     <= elig_next;
            draw_reg     <= draw_next;
            acc_reg      <= acc_next;
            winner_reg   <= winner_next;
            win_tix_reg  <= win_tix_next;
            win_wins_reg <= win_wins_next;
            res_reg      <= res_next;
        end
    end

    assign busy      = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

endmodule

### rtl/aging_lottery_selector_core.sv
// Aging lottery selector: top level with request intake and response register.
// An add writes its entry; set-last and read fetch theirs via a read-wait state; a pick
// walks the entries from the start index to the winner, then sweeps them all to age the
// tickets. A full add, an empty pick and an out-of-range set-last or read skip the memory.
// Throughput: one request at a time, set by the walk and aging sweep over the single-read-
// port entry memory; the next request enters while a response waits.
// Reset clears the entry count, ticket total and last winner; entries are undefined.
module aging_lottery_selector_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  als_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output als_pkg::rsp_t rsp
);
    import als_pkg::*;

    logic     busy;
    logic     start;
    logic     res_valid;
    logic     res_take;
    rsp_t     res;
    mem_req_t mreq;
    entry_t   rd_data;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg,       rsp_next;

    // Hold off new requests while the sequencer works on one.
    assign req_stall = busy;
    assign start     = req_valid && !req_stall;

    // Load the response register when it is empty or being drained this cycle.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    als_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .res_take  (res_take),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .mreq      (mreq),
        .rd_data   (rd_data)
    );

    als_ram u_ram (
        .clk     (clk),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        // drop the response once it is taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        // advance a finished result into the output stage
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/tb_aging_lottery_selector_core.sv
// Self-checking bench for aging_lottery_selector_core: table-driven directed requests,
// then weighted random requests, each checked against an in-bench lottery predictor
// or a hand-written response. Depends on als_pkg and the core RTL only.
module tb_aging_lottery_selector_core;
    import als_pkg::*;

    localparam int          N_DIR       = 20;
    localparam int          N_RANDOM    = 600;
    localparam int          LONG_HOLD   = 600;
    localparam int          DRAIN       = 160;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam longint unsigned TOTAL_CAP = (64'd1 << TOTAL_W) - 1;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    // One directed row: the request, and a hand-written response where it is obvious.
    typedef struct packed {
        req_t rq;
        logic typed;
        rsp_t want;
    } drow_t;

    // Predicted contents of the selector, updated as each request is accepted.
    logic [TICKET_BITS-1:0] tickets_m [MAX_ENTRIES];
    logic [WIN_BITS-1:0]    wins_m    [MAX_ENTRIES];
    int unsigned            entry_cnt;
    longint unsigned        ticket_sum;
    int unsigned            last_idx;
    bit                     has_last;

    rsp_t        outcome_q [$];
    int          fail_cnt;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left;

    aging_lottery_selector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hold reset at the start, then release it once.
    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Total tickets that can still win: the last winner's share drops out.
    function automatic longint unsigned eligible_now();
        longint unsigned sub;
        sub = 0;
        if (has_last && last_idx < entry_cnt)
            sub = tickets_m[last_idx];
        return (ticket_sum >= sub) ? ticket_sum - sub : 0;
    endfunction

    // Build a response; entry fields stay zero unless the entry is reported.
    function automatic rsp_t entry_report(status_t st, int unsigned idx, bit show);
        rsp_t            r;
        longint unsigned e;
        r = '0;
        e = eligible_now();
        r.status = st;
        r.eligible_total = (e > TOTAL_CAP) ? TOTAL_CAP[21:0] : e[21:0];
        if (show && idx < entry_cnt)
        begin
            r.chosen_index   = 6'(idx);
            r.entry_tickets  = tickets_m[idx];
            r.entry_wins     = wins_m[idx];
            r.is_last_winner = has_last && (last_idx == idx);
        end
        return r;
    endfunction

    // Apply one request to the predicted state and return the response it yields.
    function automatic rsp_t lottery_outcome(req_t r);
        int unsigned     n;
        int unsigned     first;
        int unsigned     k;
        int unsigned     idx;
        int unsigned     winner;
        longint unsigned pool;
        longint unsigned draw;
        longint unsigned acc;
        bit              skip;
        bit              found;
        case (r.mode)
            MODE_ADD:
            begin
                if (entry_cnt >= MAX_ENTRIES)
                    return entry_report(STATUS_FULL, 0, 1'b0);
                tickets_m[entry_cnt] = r.initial_tickets;
                wins_m[entry_cnt]    = r.initial_wins;
                ticket_sum += r.initial_tickets;
                entry_cnt++;
                return entry_report(STATUS_OK, entry_cnt - 1, 1'b1);
            end
            MODE_PICK:
            begin
                if (entry_cnt == 0)
                    return entry_report(STATUS_INVALID, 0, 1'b0);
                n     = entry_cnt;
                first = (r.random_start >= n) ? n - 1 : r.random_start;
                skip  = has_last && n > 1 && last_idx < n;
                pool  = 0;
                for (k = 0; k < n; k++)
                    if (!(skip && k == last_idx))
                        pool += tickets_m[k];
                // Clamp the draw; a draw equal to the pool wraps to zero.
                draw = (r.random_draw > pool) ? pool : r.random_draw;
                if (draw == pool)
                    draw = 0;
                winner = first;
                found  = 1'b0;
                acc    = 0;
                for (k = 0; k < n && !found; k++)
                begin
                    idx = (first + k) % n;
                    if (!(skip && idx == last_idx))
                    begin
                        acc += tickets_m[idx];
                        if (pool == 0 || acc > draw)
                        begin
                            winner = idx;
                            found  = 1'b1;
                        end
                    end
                end
                // Age the table: winner loses a ticket (floor one), the rest gain one.
                ticket_sum = 0;
                for (k = 0; k < n; k++)
                begin
                    if (k == winner)
                    begin
                        if (tickets_m[k] > TICKET_ONE)
                            tickets_m[k] = tickets_m[k] - TICKET_ONE;
                    end
                    else if (tickets_m[k] != TICKET_MAX)
                        tickets_m[k] = tickets_m[k] + TICKET_ONE;
                    ticket_sum += tickets_m[k];
                end
                if (wins_m[winner] != WIN_MAX)
                    wins_m[winner] = wins_m[winner] + 1'b1;
                last_idx = winner;
                has_last = 1'b1;
                return entry_report(STATUS_OK, winner, 1'b1);
            end
            MODE_SET_LAST:
            begin
                if (r.entry_index < entry_cnt)
                begin
                    last_idx = r.entry_index;
                    has_last = 1'b1;
                    return entry_report(STATUS_OK, r.entry_index, 1'b1);
                end
                has_last = 1'b0;
                last_idx = 0;
                return entry_report((r.entry_index >= CLEAR_INDEX) ? STATUS_OK : STATUS_INVALID,
                                    0, 1'b0);
            end
            default:
            begin
                if (r.entry_index < entry_cnt)
                    return entry_report(STATUS_OK, r.entry_index, 1'b1);
                return entry_report(STATUS_INVALID, 0, 1'b0);
            end
        endcase
    endfunction

    function automatic req_t req_of(mode_t m, logic [6:0] ix, logic [15:0] t, logic [15:0] w,
                                    logic [5:0] s, logic [21:0] d);
        req_t r;
        r.mode            = m;
        r.entry_index     = ix;
        r.initial_tickets = t;
        r.initial_wins    = w;
        r.random_start    = s;
        r.random_draw     = d;
        return r;
    endfunction

    function automatic rsp_t rsp_of(status_t st, logic [5:0] ix, logic [15:0] t,
                                    logic [15:0] w, logic [21:0] e, logic lw);
        rsp_t r;
        r.status         = st;
        r.chosen_index   = ix;
        r.entry_tickets  = t;
        r.entry_wins     = w;
        r.eligible_total = e;
        r.is_last_winner = lw;
        return r;
    endfunction

    // Random request; add_pct sets how fast the table fills.
    function automatic req_t random_request(int unsigned add_pct);
        req_t            r;
        int unsigned     roll;
        longint unsigned pool;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            r.mode = MODE_ADD;
        else if (roll < add_pct + 55)
            r.mode = MODE_PICK;
        else if (roll < add_pct + 75)
            r.mode = MODE_SET_LAST;
        else
            r.mode = MODE_READ;
        // Mostly aim at live entries, sometimes anywhere in the index range.
        if (entry_cnt != 0 && $urandom_range(0, 4) != 0)
            r.entry_index = 7'($urandom_range(0, entry_cnt - 1));
        else
            r.entry_index = 7'($urandom);
        case ($urandom_range(0, 4))
            0, 1:    r.initial_tickets = 16'($urandom_range(0, 8));
            2:       r.initial_tickets = 16'($urandom_range(65530, 65535));
            default: r.initial_tickets = 16'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0)
            r.initial_wins = 16'($urandom_range(65533, 65535));
        else
            r.initial_wins = 16'($urandom);
        r.random_start = 6'($urandom);
        // Keep most draws near the live pool so every entry gets a chance to win.
        pool = eligible_now();
        if ($urandom_range(0, 4) < 3)
            r.random_draw = 22'($urandom_range(0, 32'(pool) + 1));
        else
            r.random_draw = 22'($urandom);
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its predicted response.
    // Close out a burst with a random gap of idle cycles.
    task automatic offer(input req_t r, input logic typed, input rsp_t want);
        rsp_t        got;
        int unsigned gap;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        got = lottery_outcome(r);
        outcome_q.push_back(typed ? want : got);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    initial
    begin : stimulus
        drow_t dir_rows [N_DIR];
        int    i;
        req_valid  <= 1'b0;
        req        <= '0;
        fail_cnt   = 0;
        burst_left = 0;
        entry_cnt  = 0;
        ticket_sum = 0;
        last_idx   = 0;
        has_last   = 1'b0;

        //                      mode           idx  tickets wins   start draw
        // Empty table: pick and read fail, set-last clears with or without an error.
        dir_rows[0]  = '{req_of(MODE_PICK,     0,   0,      0,     0,  0),       1'b1,
                         rsp_of(STATUS_INVALID, 0, 0, 0, 0, 1'b0)};
        dir_rows[1]  = '{req_of(MODE_READ,     0,   0,      0,     0,  0),       1'b1,
                         rsp_of(STATUS_INVALID, 0, 0, 0, 0, 1'b0)};
        dir_rows[2]  = '{req_of(MODE_SET_LAST, 64,  0,      0,     0,  0),       1'b1,
                         rsp_of(STATUS_OK, 0, 0, 0, 0, 1'b0)};
        dir_rows[3]  = '{req_of(MODE_SET_LAST, 127, 65535,  65535, 63, 4194303), 1'b1,
                         rsp_of(STATUS_OK, 0, 0, 0, 0, 1'b0)};
        dir_rows[4]  = '{req_of(MODE_SET_LAST, 3,   0,      0,     0,  0),       1'b1,
                         rsp_of(STATUS_INVALID, 0, 0, 0, 0, 1'b0)};
        // Zero-ticket entry with the win count already at its ceiling.
        dir_rows[5]  = '{req_of(MODE_ADD,      0,   0,      65535, 0,  0),       1'b1,
                         rsp_of(STATUS_OK, 0, 0, 65535, 0, 1'b0)};
        // Single entry: no tickets to draw, then wins again as last winner.
        dir_rows[6]  = '{req_of(MODE_PICK,     0,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[7]  = '{req_of(MODE_PICK,     0,   0,      0,     63, 4194303), 1'b0, '0};
        dir_rows[8]  = '{req_of(MODE_ADD,      0,   65535,  0,     0,  0),       1'b0, '0};
        dir_rows[9]  = '{req_of(MODE_ADD,      0,   0,      0,     0,  0),       1'b0, '0};
        // Skip the big entry: only zero-ticket entries remain, start is clamped.
        dir_rows[10] = '{req_of(MODE_SET_LAST, 1,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[11] = '{req_of(MODE_PICK,     0,   0,      0,     63, 12345),   1'b0, '0};
        dir_rows[12] = '{req_of(MODE_ADD,      0,   1,      1,     0,  0),       1'b0, '0};
        // Oversized draw wraps to zero; then a plain zero draw.
        dir_rows[13] = '{req_of(MODE_PICK,     0,   0,      0,     1,  4194303), 1'b0, '0};
        dir_rows[14] = '{req_of(MODE_PICK,     0,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[15] = '{req_of(MODE_READ,     63,  0,      0,     0,  0),       1'b0, '0};
        dir_rows[16] = '{req_of(MODE_SET_LAST, 5,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[17] = '{req_of(MODE_READ,     0,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[18] = '{req_of(MODE_READ,     3,   0,      0,     0,  0),       1'b0, '0};
        dir_rows[19] = '{req_of(MODE_PICK,     0,   0,      0,     3,  1),       1'b0, '0};

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        for (i = 0; i < N_DIR; i++)
            offer(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        // Grow the table slowly first, then fill it and keep adding into a full table.
        for (i = 0; i < N_RANDOM; i++)
            offer(random_request((i < N_RANDOM / 2) ? 6 : 30), 1'b0, '0);
        req_valid <= 1'b0;

        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_cnt == 0)
            $display("aging_lottery_selector_core regression: pass");
        else
            $display("aging_lottery_selector_core regression: fail");
        $finish;
    end

    // Response stall pattern: random styles in short spans, plus two long holds
    // that let the core back up and stall its request side.
    initial
    begin : rsp_pacing
        int unsigned style;
        int unsigned span;
        int unsigned cyc;
        int unsigned holds_done;
        rsp_stall <= 1'b0;
        cyc        = 0;
        holds_done = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holds_done < 2 && cyc >= 3000 * (holds_done + 1))
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                cyc += LONG_HOLD;
                holds_done++;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(4, 60);
            repeat (span)
            begin
                case (style)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= cyc[0];
                endcase
                @(posedge clk);
                cyc++;
            end
        end
    end

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_cnt++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status",         want.status,         rsp.status);
                check_field("chosen_index",   want.chosen_index,   rsp.chosen_index);
                check_field("entry_tickets",  want.entry_tickets,  rsp.entry_tickets);
                check_field("entry_wins",     want.entry_wins,     rsp.entry_wins);
                check_field("eligible_total", want.eligible_total, rsp.eligible_total);
                check_field("is_last_winner", want.is_last_winner, rsp.is_last_winner);
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("aging_lottery_selector_core regression: fail");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/als_pkg.sv
rtl/als_ram.sv
rtl/als_ctrl.sv
rtl/aging_lottery_selector_core.sv
bench/tb_aging_lottery_selector_core.sv
